// File: src/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg: shared types and calendar helpers
// Year widths, sequencer states, walker interface structs and the small
// calendar functions used by the date arithmetic core.
// ----------------------------------------------------------------------------
`default_nettype none
package gda_pkg;

	localparam int YEAR_BITS = 14;
	localparam int DAY_COUNT_BITS = 16;
	// Internal years carry two spare bits so that a wrapped output year still
	// gets the leap rule of the true year.
	localparam int YW = YEAR_BITS + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_PREP,
		ST_SHIFT,
		ST_WALK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [YW-1:0]             year;
		logic [3:0]                month;
		logic [4:0]                day;
		logic [DAY_COUNT_BITS-1:0] rem;
		logic [1:0]                c4;
		logic [6:0]                c100;
		logic [8:0]                c400;
	} walk_cmd_t;

	typedef struct packed {
		logic          idle;
		logic [YW-1:0] year;
		logic [3:0]    month;
		logic [4:0]    day;
	} walk_res_t;

	// Quotient by 100 through a reciprocal; exact for values below 43690.
	function automatic logic [YW-1:0] div100(input logic [YW-1:0] y);
		logic [YW+12:0] p;
		p = y * 13'd5243;
		return YW'(p >> 19);
	endfunction

	// Gregorian leap rule. Divisible by 100 is divisible by 4 and 25, and
	// divisible by 400 is divisible by 16 and 25.
	function automatic logic is_leap(input logic [YW-1:0] y);
		logic [YW+12:0] p;
		logic [YW-1:0]  q25;
		logic [YW-1:0]  r25;
		p = y * 13'd5243;
		q25 = YW'(p >> 17);
		r25 = y - YW'(q25 * 5'd25);
		return ((y[1:0] == 2'd0) && (r25 != '0)) || ((y[3:0] == 4'd0) && (r25 == '0));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
			default:                                    return leap ? 5'd29 : 5'd28;
		endcase
	endfunction

	// Days before the month in a March-based year, (153 * k + 2) / 5.
	function automatic logic [8:0] march_days(input logic [3:0] m);
		case (m)
			4'd3:    return 9'd0;
			4'd4:    return 9'd31;
			4'd5:    return 9'd61;
			4'd6:    return 9'd92;
			4'd7:    return 9'd122;
			4'd8:    return 9'd153;
			4'd9:    return 9'd184;
			4'd10:   return 9'd214;
			4'd11:   return 9'd245;
			4'd12:   return 9'd275;
			4'd1:    return 9'd306;
			4'd2:    return 9'd337;
			default: return 9'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: src/gda_month_walker.sv
// ----------------------------------------------------------------------------
// gda_month_walker: advances a date by a day count
// Consumes the remaining count one month per cycle, keeping the year's
// residues modulo 4, 100 and 400 so the leap rule needs no division.
// ----------------------------------------------------------------------------
`default_nettype none
module gda_month_walker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire gda_pkg::walk_cmd_t cmd,
	output gda_pkg::walk_res_t      res
);
	import gda_pkg::*;

	logic                      busy_q;
	logic [YW-1:0]             year_q;
	logic [3:0]                month_q;
	logic [4:0]                day_q;
	logic [DAY_COUNT_BITS-1:0] rem_q;
	logic [1:0]                c4_q;
	logic [6:0]                c100_q;
	logic [8:0]                c400_q;

	logic                      leap;
	logic [5:0]                left;

	assign leap = ((c4_q == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);
	assign left = 6'(month_len(month_q, leap)) - 6'(day_q) + 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if ((rem_q == '0) || (rem_q < DAY_COUNT_BITS'(left))) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			year_q  <= cmd.year;
			month_q <= cmd.month;
			day_q   <= cmd.day;
			rem_q   <= cmd.rem;
			c4_q    <= cmd.c4;
			c100_q  <= cmd.c100;
			c400_q  <= cmd.c400;
		end else if (busy_q && (rem_q != '0)) begin
			if (rem_q < DAY_COUNT_BITS'(left)) begin
				day_q <= day_q + rem_q[4:0];
				rem_q <= '0;
			end else begin
				rem_q <= rem_q - DAY_COUNT_BITS'(left);
				day_q <= 5'd1;
				if (month_q == 4'd12) begin
					month_q <= 4'd1;
					year_q  <= year_q + 1'b1;
					c4_q    <= c4_q + 1'b1;
					c100_q  <= (c100_q == 7'd99) ? 7'd0 : c100_q + 1'b1;
					c400_q  <= (c400_q == 9'd399) ? 9'd0 : c400_q + 1'b1;
				end else begin
					month_q <= month_q + 1'b1;
				end
			end
		end
	end

	assign res.idle  = !busy_q;
	assign res.year  = year_q;
	assign res.month = month_q;
	assign res.day   = day_q;

endmodule
`default_nettype wire

// File: src/gregorian_date_arithmetic_core.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core: Gregorian date arithmetic
// Advances a date by days, shifts it by months, and reports the serial day
// number, age in years, leap flag, month length and an invalid-date flag.
// ----------------------------------------------------------------------------
// Sequence: a bad date goes from the calculation step straight to the finishing
// step; a good date passes the calculation, preparation, shift and walk steps,
// where the walk lasts until the month walker has consumed the whole day count.
// The done strobe is registered from the finishing step.
// Throughput: one word at a time; busy stays high until the result strobe.
// The result is shown for one cycle on done and cannot be stalled.
// Reset clears the sequencer and the strobe; result registers are not reset.
`default_nettype none
module gregorian_date_arithmetic_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [gda_pkg::YEAR_BITS-1:0]      year,
	input  wire logic [3:0]                         month,
	input  wire logic [4:0]                         day,
	input  wire logic [gda_pkg::DAY_COUNT_BITS-1:0] days_to_add,
	input  wire logic [11:0]                        months_to_add,
	input  wire logic [gda_pkg::YEAR_BITS-1:0]      ref_year,
	input  wire logic [3:0]                         ref_month,
	input  wire logic [4:0]                         ref_day,
	output logic                                    busy,
	output logic                                    done,
	output logic [gda_pkg::YEAR_BITS-1:0]           adv_year,
	output logic [3:0]                              adv_month,
	output logic [4:0]                              adv_day,
	output logic [gda_pkg::YEAR_BITS-1:0]           shifted_year,
	output logic [3:0]                              shifted_month,
	output logic [4:0]                              shifted_day,
	output logic [21:0]                             day_number,
	output logic [13:0]                             age_years,
	output logic                                    leap_year,
	output logic [4:0]                              month_length,
	output logic                                    bad_date
);
	import gda_pkg::*;

	localparam logic [21:0] DAYNUM_MAX = 22'h3FFFFF;

	state_t state_q, state_d;

	// Captured input word.
	logic [YW-1:0]             yr_q;
	logic [3:0]                mo_q;
	logic [4:0]                dy_q;
	logic [DAY_COUNT_BITS-1:0] ndays_q;
	logic [11:0]               nmon_q;
	logic [YW-1:0]             ry_q;
	logic [3:0]                rm_q;
	logic [4:0]                rd_q;

	// Intermediate results of the sequencer steps.
	logic                      leap_q;
	logic [4:0]                mlen_q;
	logic                      bad_q;
	logic [YW-1:0]             q100y_q;
	logic                      dneg_q;
	logic [YW-1:0]             ydn_q;
	logic [YW-1:0]             q100d_q;
	logic [12:0]               tot_q;
	logic [12:0]               q12_q;
	logic [13:0]               age_q;
	logic [YW-1:0]             shy_q;
	logic [3:0]                shm_q;
	logic [4:0]                shd_q;
	logic [21:0]               dn_q;

	logic                      done_q;

	// Calculation step.
	logic                      c_leap;
	logic [4:0]                c_mlen;
	logic                      c_bad;
	logic                      c_early;
	logic [12:0]               c_tot;
	logic [25:0]               c_p12;
	logic [YW:0]               c_age;

	assign c_leap  = is_leap(yr_q);
	assign c_mlen  = month_len(mo_q, c_leap);
	assign c_bad   = (mo_q < 4'd1) || (mo_q > 4'd12) || (dy_q == 5'd0) || (dy_q > c_mlen);
	assign c_early = (mo_q <= 4'd2);
	assign c_tot   = 13'(mo_q) - 13'd1 + 13'(nmon_q);
	assign c_p12   = c_tot * 13'd2731;
	// Age is one less when the reference falls before the birthday in its year.
	assign c_age   = {1'b0, ry_q} - {1'b0, yr_q}
		- (YW+1)'(((rm_q < mo_q) || ((rm_q == mo_q) && (rd_q < dy_q))) ? 1 : 0);

	// Preparation step: residues for the walker, shifted year and month, day number.
	walk_cmd_t                 cmd;
	walk_res_t                 res;
	logic                      wload;
	logic signed [24:0]        p_dn;
	logic [21:0]               p_dnc;

	assign cmd.year  = yr_q;
	assign cmd.month = mo_q;
	assign cmd.day   = dy_q;
	assign cmd.rem   = ndays_q;
	assign cmd.c4    = yr_q[1:0];
	assign cmd.c100  = 7'(yr_q - YW'(q100y_q * 7'd100));
	assign cmd.c400  = 9'(yr_q - YW'((q100y_q >> 2) * 9'd400));

	always_comb begin
		if (dneg_q) begin
			// Only year zero in January or February lands here.
			p_dn = -25'sd365 + $signed(25'(march_days(mo_q))) + $signed(25'(dy_q));
		end else begin
			p_dn = $signed(25'(ydn_q * 9'd365)) + $signed(25'(ydn_q >> 2))
				- $signed(25'(q100d_q)) + $signed(25'(q100d_q >> 2))
				+ $signed(25'(march_days(mo_q))) + $signed(25'(dy_q));
		end
		if (p_dn < 0) begin
			p_dnc = '0;
		end else if (p_dn > $signed(25'(DAYNUM_MAX))) begin
			p_dnc = DAYNUM_MAX;
		end else begin
			p_dnc = p_dn[21:0];
		end
	end

	// Shift step: clamp the day to the target month.
	logic [4:0] s_lim;
	assign s_lim = month_len(shm_q, is_leap(shy_q));

	gda_month_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (wload),
		.cmd    (cmd),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
		end
	end

	always_comb begin
		state_d = state_q;
		wload   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = c_bad ? ST_FIN : ST_PREP;
			end
			ST_PREP: begin
				wload   = 1'b1;
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (res.idle) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					yr_q    <= YW'(year);
					mo_q    <= month;
					dy_q    <= day;
					ndays_q <= days_to_add;
					nmon_q  <= months_to_add;
					ry_q    <= YW'(ref_year);
					rm_q    <= ref_month;
					rd_q    <= ref_day;
				end
			end
			ST_CALC: begin
				leap_q  <= c_leap;
				mlen_q  <= c_mlen;
				bad_q   <= c_bad;
				q100y_q <= div100(yr_q);
				dneg_q  <= c_early && (yr_q == '0);
				ydn_q   <= yr_q - YW'(c_early);
				q100d_q <= div100(yr_q - YW'(c_early));
				tot_q   <= c_tot;
				q12_q   <= 13'(c_p12 >> 15);
				age_q   <= c_age[YW] ? 14'd0 : c_age[13:0];
			end
			ST_PREP: begin
				shy_q <= yr_q + YW'(q12_q);
				shm_q <= 4'(tot_q - 13'(q12_q * 4'd12)) + 4'd1;
				dn_q  <= p_dnc;
			end
			ST_SHIFT: begin
				shd_q <= (dy_q < s_lim) ? dy_q : s_lim;
			end
			ST_FIN: begin
				bad_date      <= bad_q;
				adv_year      <= bad_q ? '0 : res.year[YEAR_BITS-1:0];
				adv_month     <= bad_q ? '0 : res.month;
				adv_day       <= bad_q ? '0 : res.day;
				shifted_year  <= bad_q ? '0 : shy_q[YEAR_BITS-1:0];
				shifted_month <= bad_q ? '0 : shm_q;
				shifted_day   <= bad_q ? '0 : shd_q;
				day_number    <= bad_q ? '0 : dn_q;
				age_years     <= bad_q ? '0 : age_q;
				leap_year     <= bad_q ? 1'b0 : leap_q;
				month_length  <= bad_q ? '0 : mlen_q;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

`ifndef NO_ASSERTIONS
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("result strobe without a finishing step");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_date) |-> (day_number == '0 && age_years == '0 && adv_month == '0))
		else $error("bad date left a nonzero result");
	a_good_month: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !bad_date) |-> (adv_month >= 4'd1 && adv_month <= 4'd12
			&& shifted_month >= 4'd1 && shifted_month <= 4'd12 && adv_day != 5'd0))
		else $error("valid date produced an out of range month or day");
	a_walk_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |=> !res.idle)
		else $error("month walker did not start");
`endif

endmodule
`default_nettype wire

// File: sim/tb_gregorian_date_arithmetic_core.sv
// ----------------------------------------------------------------------------
// tb_gregorian_date_arithmetic_core: self-checking bench for the date core
// Drives directed and random date words through the command handshake,
// predicts every result field and compares each strobed result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_gregorian_date_arithmetic_core;
	import gda_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	// One input word and one result word as the bench sees them.
	typedef struct {
		logic [YEAR_BITS-1:0]      year;
		logic [3:0]                month;
		logic [4:0]                day;
		logic [DAY_COUNT_BITS-1:0] ndays;
		logic [11:0]               nmonths;
		logic [YEAR_BITS-1:0]      ref_year;
		logic [3:0]                ref_month;
		logic [4:0]                ref_day;
	} date_word_t;

	typedef struct {
		logic [YEAR_BITS-1:0] adv_year;
		logic [3:0]           adv_month;
		logic [4:0]           adv_day;
		logic [YEAR_BITS-1:0] shifted_year;
		logic [3:0]           shifted_month;
		logic [4:0]           shifted_day;
		logic [21:0]          day_number;
		logic [13:0]          age_years;
		logic                 leap_year;
		logic [4:0]           month_length;
		logic                 bad_date;
	} date_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [YEAR_BITS-1:0] year = '0;
	logic [3:0] month = '0;
	logic [4:0] day = '0;
	logic [DAY_COUNT_BITS-1:0] days_to_add = '0;
	logic [11:0] months_to_add = '0;
	logic [YEAR_BITS-1:0] ref_year = '0;
	logic [3:0] ref_month = '0;
	logic [4:0] ref_day = '0;
	logic busy, done;
	logic [YEAR_BITS-1:0] adv_year, shifted_year;
	logic [3:0] adv_month, shifted_month;
	logic [4:0] adv_day, shifted_day, month_length;
	logic [21:0] day_number;
	logic [13:0] age_years;
	logic leap_year, bad_date;

	date_result_t pending_results[$];
	int failures = 0;
	int words_sent = 0;
	int results_seen = 0;
	int bad_seen = 0;
	int idle_cycles = 0;

	always #1 clk = ~clk;

	gregorian_date_arithmetic_core dut (.*);

	// Leap rule on the full, unwrapped year.
	function automatic bit leap_of(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic int unsigned days_in(int unsigned y, int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			default:               return leap_of(y) ? 29 : 28;
		endcase
	endfunction

	// Computes the full result word for one input date word.
	function automatic date_result_t predict_dates(date_word_t w);
		date_result_t r;
		int unsigned y, m, d, rest, left, total;
		longint sy, sm, serial;
		int age;
		r = '{default: '0};
		if (w.month < 1 || w.month > 12 || w.day == 0 || w.day > days_in(w.year, w.month)) begin
			r.bad_date = 1'b1;
			return r;
		end
		// Day advance, one month at a time.
		y = w.year;
		m = w.month;
		d = w.day;
		rest = w.ndays;
		while (rest > 0) begin
			left = days_in(y, m) - d + 1;
			if (rest < left) begin
				d += rest;
				break;
			end
			rest -= left;
			d = 1;
			m++;
			if (m > 12) begin
				m = 1;
				y++;
			end
		end
		r.adv_year = y[YEAR_BITS-1:0];
		r.adv_month = m[3:0];
		r.adv_day = d[4:0];
		// Month shift with the day clamped to the target month.
		total = w.month - 1 + w.nmonths;
		y = w.year + total / 12;
		m = total % 12 + 1;
		r.shifted_year = y[YEAR_BITS-1:0];
		r.shifted_month = m[3:0];
		left = days_in(y, m);
		r.shifted_day = (w.day < left) ? w.day : left[4:0];
		// Serial day number on a year that starts in March.
		sy = w.year;
		sm = w.month;
		if (sm <= 2) begin
			sy -= 1;
			sm += 12;
		end
		serial = sy * 365 + (153 * (sm - 3) + 2) / 5 + w.day;
		if (sy >= 0)
			serial += sy / 4 - sy / 100 + sy / 400;
		if (serial < 0)
			serial = 0;
		if (serial > 4194303)
			serial = 4194303;
		r.day_number = serial[21:0];
		age = int'(w.ref_year) - int'(w.year);
		if (w.ref_month < w.month || (w.ref_month == w.month && w.ref_day < w.day))
			age--;
		if (age < 0)
			age = 0;
		r.age_years = age[13:0];
		r.leap_year = leap_of(w.year);
		r.month_length = 5'(days_in(w.year, w.month));
		return r;
	endfunction

	// Presents one word from a falling edge and waits for it to be taken.
	task automatic send_word(date_word_t w);
		@(negedge clk);
		start <= 1'b1;
		year <= w.year;
		month <= w.month;
		day <= w.day;
		days_to_add <= w.ndays;
		months_to_add <= w.nmonths;
		ref_year <= w.ref_year;
		ref_month <= w.ref_month;
		ref_day <= w.ref_day;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_dates(w));
		words_sent++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Random idle gap between bursts of words.
	task automatic sender_gap();
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0) @(negedge clk);
	endtask

	function automatic date_word_t make_word(int y, int m, int d, int nd, int nm,
			int ry, int rm, int rd);
		date_word_t w;
		w.year = YEAR_BITS'(y);
		w.month = 4'(m);
		w.day = 5'(d);
		w.ndays = DAY_COUNT_BITS'(nd);
		w.nmonths = 12'(nm);
		w.ref_year = YEAR_BITS'(ry);
		w.ref_month = 4'(rm);
		w.ref_day = 5'(rd);
		return w;
	endfunction

	// A valid date with random fields; day counts are mostly small so the
	// month walk stays short, with an occasional long one.
	function automatic date_word_t random_valid_word();
		date_word_t w;
		int y;
		int m;
		y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
		m = $urandom_range(1, 12);
		w = make_word(y, m, $urandom_range(1, days_in(y, m)), 0, $urandom_range(0, 4095),
			$urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
		case ($urandom_range(0, 9))
			0:       w.ndays = DAY_COUNT_BITS'($urandom_range(0, 65535));
			1, 2:    w.ndays = DAY_COUNT_BITS'($urandom_range(0, 4000));
			default: w.ndays = DAY_COUNT_BITS'($urandom_range(0, 400));
		endcase
		if ($urandom_range(0, 2) == 0)
			w.ref_year = YEAR_BITS'(y + $urandom_range(0, 100));
		return w;
	endfunction

	task automatic test_field_extremes();
		send_word(make_word(1, 1, 1, 0, 0, 1, 1, 1));
		send_word(make_word(9999, 12, 31, 65535, 4095, 9999, 12, 31));
		send_word(make_word(16383, 12, 31, 65535, 4095, 16383, 15, 31));
		send_word(make_word(16383, 2, 29, 1, 11, 0, 0, 0));
		send_word(make_word(1, 1, 1, 65535, 4095, 16383, 1, 1));
	endtask

	task automatic test_leap_rules();
		send_word(make_word(2000, 2, 29, 1, 12, 2024, 2, 28));
		send_word(make_word(1900, 2, 28, 1, 12, 1901, 2, 28));
		send_word(make_word(2024, 1, 31, 29, 1, 2025, 1, 31));
		send_word(make_word(2023, 1, 31, 28, 1, 2023, 1, 30));
		send_word(make_word(2400, 2, 29, 366, 48, 2399, 3, 1));
	endtask

	task automatic test_year_zero();
		// Year zero is a leap year; its January and February map below zero.
		send_word(make_word(0, 1, 1, 0, 0, 0, 1, 1));
		send_word(make_word(0, 2, 29, 1, 0, 5, 3, 1));
		send_word(make_word(0, 3, 1, 0, 0, 0, 0, 0));
	endtask

	task automatic test_bad_dates();
		send_word(make_word(2023, 0, 10, 5, 5, 2030, 1, 1));
		send_word(make_word(2023, 13, 10, 5, 5, 2030, 1, 1));
		send_word(make_word(2023, 15, 31, 5, 5, 2030, 1, 1));
		send_word(make_word(2023, 4, 0, 5, 5, 2030, 1, 1));
		send_word(make_word(2023, 4, 31, 5, 5, 2030, 1, 1));
		send_word(make_word(2023, 2, 29, 5, 5, 2030, 1, 1));
		send_word(make_word(1900, 2, 29, 5, 5, 2030, 1, 1));
	endtask

	task automatic test_age_edges();
		// Birthday not yet reached, reached today, and reference in the past.
		send_word(make_word(1990, 6, 15, 0, 0, 2020, 6, 14));
		send_word(make_word(1990, 6, 15, 0, 0, 2020, 6, 15));
		send_word(make_word(1990, 6, 15, 0, 0, 1980, 6, 15));
	endtask

	task automatic test_random_words(int count);
		date_word_t w;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				sender_gap();
				burst = $urandom_range(1, 30);
			end
			burst--;
			if ($urandom_range(0, 9) == 0) begin
				w = make_word($urandom_range(0, 16383), $urandom_range(0, 15),
					$urandom_range(0, 31), $urandom_range(0, 65535),
					$urandom_range(0, 4095), $urandom_range(0, 16383),
					$urandom_range(0, 15), $urandom_range(0, 31));
				if (w.ndays > 2000)
					w.ndays = DAY_COUNT_BITS'(w.ndays[10:0]);
			end else
				w = random_valid_word();
			send_word(w);
		end
	endtask

	// Compares each strobed result with the oldest expectation.
	always @(posedge clk) begin
		date_result_t e;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result strobe with no word outstanding");
				failures++;
			end else begin
				e = pending_results.pop_front();
				if (e.bad_date)
					bad_seen++;
				if (adv_year !== e.adv_year) begin
					$error("adv_year expected %0d got %0d", e.adv_year, adv_year);
					failures++;
				end
				if (adv_month !== e.adv_month) begin
					$error("adv_month expected %0d got %0d", e.adv_month, adv_month);
					failures++;
				end
				if (adv_day !== e.adv_day) begin
					$error("adv_day expected %0d got %0d", e.adv_day, adv_day);
					failures++;
				end
				if (shifted_year !== e.shifted_year) begin
					$error("shifted_year expected %0d got %0d", e.shifted_year, shifted_year);
					failures++;
				end
				if (shifted_month !== e.shifted_month) begin
					$error("shifted_month expected %0d got %0d", e.shifted_month,
						shifted_month);
					failures++;
				end
				if (shifted_day !== e.shifted_day) begin
					$error("shifted_day expected %0d got %0d", e.shifted_day, shifted_day);
					failures++;
				end
				if (day_number !== e.day_number) begin
					$error("day_number expected %0d got %0d", e.day_number, day_number);
					failures++;
				end
				if (age_years !== e.age_years) begin
					$error("age_years expected %0d got %0d", e.age_years, age_years);
					failures++;
				end
				if (leap_year !== e.leap_year) begin
					$error("leap_year expected %0d got %0d", e.leap_year, leap_year);
					failures++;
				end
				if (month_length !== e.month_length) begin
					$error("month_length expected %0d got %0d", e.month_length, month_length);
					failures++;
				end
				if (bad_date !== e.bad_date) begin
					$error("bad_date expected %0d got %0d", e.bad_date, bad_date);
					failures++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither a word nor a result moves.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_leap_rules();
		test_year_zero();
		test_bad_dates();
		test_age_edges();
		test_random_words(1000);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d date words and checked %0d results, %0d of them invalid dates.",
			words_sent, results_seen, bad_seen);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
